>>> hw/rtl/biquad_iir_filter_macros.svh
// ----------------------------------------------------------------------------
// Biquad filter assertion macros
// Shared concurrent assertion forms for the biquad filter modules.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bq_pkg.sv
// ----------------------------------------------------------------------------
// Biquad filter package
// Fixed-point constants, register indexes, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package bq_pkg;

	localparam int DELAY_FRAC = 8;
	localparam int COEF_FRAC  = 16;
	localparam int PROD_FRAC  = COEF_FRAC + DELAY_FRAC;

	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN_0 = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN_1 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN_2 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FB_GAIN_1 = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FB_GAIN_2 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FB_MAC,
		ST_FB_DONE,
		ST_FF_MAC,
		ST_FF_DONE
	} bq_state_t;

	typedef struct packed {
		logic load_fb;
		logic load_ff;
		logic step;
		logic first;
		logic fb_phase;
		logic commit;
	} bq_ctrl_t;

endpackage

>>> hw/rtl/bq_ctrl.sv
// ----------------------------------------------------------------------------
// Biquad filter sequencer
// Steps the bit-serial feedback and feed-forward passes of one item.
// ----------------------------------------------------------------------------
module bq_ctrl #(
	parameter int COEF_BITS = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             out_free,
	output logic             in_ready,
	output bq_pkg::bq_ctrl_t ctrl
);

	localparam int CNT_BITS = $clog2(COEF_BITS);
	localparam logic [CNT_BITS-1:0] CNT_TOP = CNT_BITS'(COEF_BITS - 1);

	bq_pkg::bq_state_t state_q;
	bq_pkg::bq_state_t state_next;
	logic [CNT_BITS-1:0] cnt_q;
	logic last_bit;

	assign last_bit = (cnt_q == '0);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = bq_pkg::ST_FB_MAC;
				end
			end
			bq_pkg::ST_FB_MAC: begin
				if (last_bit) begin
					state_next = bq_pkg::ST_FB_DONE;
				end
			end
			bq_pkg::ST_FB_DONE: begin
				state_next = bq_pkg::ST_FF_MAC;
			end
			bq_pkg::ST_FF_MAC: begin
				if (last_bit) begin
					state_next = bq_pkg::ST_FF_DONE;
				end
			end
			bq_pkg::ST_FF_DONE: begin
				if (out_free) begin
					state_next = bq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = (state_q == bq_pkg::ST_IDLE);
		ctrl.load_fb  = (state_q == bq_pkg::ST_IDLE) && in_valid;
		ctrl.load_ff  = (state_q == bq_pkg::ST_FB_DONE);
		ctrl.fb_phase = (state_q == bq_pkg::ST_FB_MAC);
		ctrl.step     = (state_q == bq_pkg::ST_FB_MAC) || (state_q == bq_pkg::ST_FF_MAC);
		ctrl.first    = (cnt_q == CNT_TOP);
		ctrl.commit   = (state_q == bq_pkg::ST_FF_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (ctrl.load_fb || ctrl.load_ff) begin
				cnt_q <= CNT_TOP;
			end else if (ctrl.step && !last_bit) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/bq_datapath.sv
// ----------------------------------------------------------------------------
// Biquad filter datapath
// Bit-serial multiply-accumulate over coefficient shift registers, rounding,
// saturation and the two delay words.
// ----------------------------------------------------------------------------
module bq_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bq_pkg::bq_ctrl_t              ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic signed [COEF_BITS-1:0]   ff_gain_0,
	input  logic signed [COEF_BITS-1:0]   ff_gain_1,
	input  logic signed [COEF_BITS-1:0]   ff_gain_2,
	input  logic signed [COEF_BITS-1:0]   fb_gain_1,
	input  logic signed [COEF_BITS-1:0]   fb_gain_2,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int D_BITS   = SAMPLE_BITS + bq_pkg::DELAY_FRAC;
	localparam int P_BITS   = COEF_BITS + D_BITS;
	localparam int X_BITS   = SAMPLE_BITS + bq_pkg::PROD_FRAC;
	localparam int ACC_BITS = ((P_BITS > X_BITS) ? P_BITS : X_BITS) + 2;

	localparam logic signed [ACC_BITS-1:0] W_HALF = ACC_BITS'(1) << (bq_pkg::COEF_FRAC - 1);
	localparam logic signed [ACC_BITS-1:0] Y_HALF = ACC_BITS'(1) << (bq_pkg::PROD_FRAC - 1);
	localparam logic signed [ACC_BITS-1:0] W_HI =
		signed'({{(ACC_BITS-D_BITS+1){1'b0}}, {(D_BITS-1){1'b1}}});
	localparam logic signed [ACC_BITS-1:0] W_LO = ~W_HI;
	localparam logic signed [ACC_BITS-1:0] Y_HI =
		signed'({{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [ACC_BITS-1:0] Y_LO = ~Y_HI;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic        [COEF_BITS-1:0]   sh0_q;
	logic        [COEF_BITS-1:0]   sh1_q;
	logic        [COEF_BITS-1:0]   sh2_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [D_BITS-1:0]      w0_q;
	logic signed [D_BITS-1:0]      w1_q;
	logic signed [D_BITS-1:0]      w2_q;

	logic signed [D_BITS-1:0]   t0;
	logic signed [D_BITS-1:0]   t1;
	logic signed [D_BITS-1:0]   t2;
	logic signed [D_BITS+1:0]   term;
	logic signed [ACC_BITS-1:0] term_ext;
	logic signed [ACC_BITS-1:0] acc_dbl;
	logic signed [ACC_BITS-1:0] acc_next;
	logic                       sub;
	logic signed [ACC_BITS-1:0] x_ext;
	logic signed [ACC_BITS-1:0] w_rnd;
	logic signed [D_BITS-1:0]   w_sat;
	logic signed [ACC_BITS-1:0] y_rnd;

	always_comb begin
		t0       = sh0_q[COEF_BITS-1] ? w0_q : '0;
		t1       = sh1_q[COEF_BITS-1] ? w1_q : '0;
		t2       = sh2_q[COEF_BITS-1] ? w2_q : '0;
		term     = {{2{t0[D_BITS-1]}}, t0} + {{2{t1[D_BITS-1]}}, t1}
			+ {{2{t2[D_BITS-1]}}, t2};
		term_ext = {{(ACC_BITS-D_BITS-2){term[D_BITS+1]}}, term};
		acc_dbl  = acc_q <<< 1;
		sub      = ctrl.first ^ ctrl.fb_phase;
		acc_next = sub ? (acc_dbl - term_ext) : (acc_dbl + term_ext);
	end

	always_comb begin
		x_ext = {{(ACC_BITS-X_BITS){x_q[SAMPLE_BITS-1]}}, x_q, {bq_pkg::PROD_FRAC{1'b0}}};
		w_rnd = (acc_q + x_ext + W_HALF) >>> bq_pkg::COEF_FRAC;
		if (w_rnd > W_HI) begin
			w_sat = W_HI[D_BITS-1:0];
		end else if (w_rnd < W_LO) begin
			w_sat = W_LO[D_BITS-1:0];
		end else begin
			w_sat = w_rnd[D_BITS-1:0];
		end
	end

	always_comb begin
		y_rnd = (acc_q + Y_HALF) >>> bq_pkg::PROD_FRAC;
		if (y_rnd > Y_HI) begin
			result = Y_HI[SAMPLE_BITS-1:0];
		end else if (y_rnd < Y_LO) begin
			result = Y_LO[SAMPLE_BITS-1:0];
		end else begin
			result = y_rnd[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_fb) begin
			x_q   <= sample_in;
			sh0_q <= '0;
			sh1_q <= fb_gain_1;
			sh2_q <= fb_gain_2;
			acc_q <= '0;
		end else if (ctrl.load_ff) begin
			sh0_q <= ff_gain_0;
			sh1_q <= ff_gain_1;
			sh2_q <= ff_gain_2;
			acc_q <= '0;
		end else if (ctrl.step) begin
			sh0_q <= sh0_q << 1;
			sh1_q <= sh1_q << 1;
			sh2_q <= sh2_q << 1;
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q <= '0;
			w1_q <= '0;
			w2_q <= '0;
		end else begin
			if (ctrl.load_ff) begin
				w0_q <= w_sat;
			end
			if (ctrl.commit) begin
				w1_q <= w0_q;
				w2_q <= w1_q;
			end
		end
	end

endmodule

>>> hw/rtl/biquad_iir_filter.sv
// ----------------------------------------------------------------------------
// Biquad IIR filter
// Second-order direct form II section with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage: samples enter on in_valid/in_ready with sample_in and leave on
// out_valid/out_ready with sample_out, one result item per input item.
// The five coefficients (b0, b1, b2, a1, a2, signed Q3.16) are written on
// cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high
// and writes to an index beyond the list are dropped. Write them only while
// no item is in flight.
// Each item makes two passes over the coefficient bits, one bit per cycle:
// the feedback pass, a rounding step, the feed-forward pass and a result
// step that waits for a free output register. A new item is taken only
// once the previous result has been committed.
// The coefficient width sets the length of each pass and so the throughput.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result then waits in the datapath
// until the output register frees up.
// Reset clears both delay words, loads b0 = 1.0 and all other coefficients
// to zero, and empties the output register.
// ----------------------------------------------------------------------------
`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter #(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SAMPLE_BITS-1:0]     sample_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic signed [COEF_BITS-1:0]       cfg_data
);

	localparam logic signed [COEF_BITS-1:0] UNITY_GAIN =
		signed'({{(COEF_BITS-1){1'b0}}, 1'b1} << bq_pkg::COEF_FRAC);

	logic signed [COEF_BITS-1:0] ff_gain_0_q;
	logic signed [COEF_BITS-1:0] ff_gain_1_q;
	logic signed [COEF_BITS-1:0] ff_gain_2_q;
	logic signed [COEF_BITS-1:0] fb_gain_1_q;
	logic signed [COEF_BITS-1:0] fb_gain_2_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic signed [SAMPLE_BITS-1:0] result;
	logic                          out_free;
	bq_pkg::bq_ctrl_t              ctrl;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_gain_0_q <= UNITY_GAIN;
			ff_gain_1_q <= '0;
			ff_gain_2_q <= '0;
			fb_gain_1_q <= '0;
			fb_gain_2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bq_pkg::REG_FF_GAIN_0: ff_gain_0_q <= cfg_data;
				bq_pkg::REG_FF_GAIN_1: ff_gain_1_q <= cfg_data;
				bq_pkg::REG_FF_GAIN_2: ff_gain_2_q <= cfg_data;
				bq_pkg::REG_FB_GAIN_1: fb_gain_1_q <= cfg_data;
				bq_pkg::REG_FB_GAIN_2: fb_gain_2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			sample_out_q <= result;
		end
	end

	bq_ctrl #(
		.COEF_BITS(COEF_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	bq_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.sample_in (sample_in),
		.ff_gain_0 (ff_gain_0_q),
		.ff_gain_1 (ff_gain_1_q),
		.ff_gain_2 (ff_gain_2_q),
		.fb_gain_1 (fb_gain_1_q),
		.fb_gain_2 (fb_gain_2_q),
		.result    (result)
	);

	`BQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while an item is in progress")

	`BQ_ASSERT_NOW(a_commit_into_free, clk, arst_n, ctrl.commit, !out_valid_q || out_ready, "result overwrote a waiting item")

	`BQ_ASSERT_NOW(a_valid_from_commit, clk, arst_n, $rose(out_valid_q), $past(ctrl.commit), "output item appeared without a finished computation")

	`BQ_ASSERT_NOW(a_no_load_clash, clk, arst_n, ctrl.load_fb || ctrl.load_ff, !ctrl.step && !ctrl.commit, "datapath load overlaps a step or commit")

endmodule
